@@ src/rlps_pkg.sv @@
// ============================================================================
// rlps_pkg: shared types and constants for the RGB LED pulse width serializer
// Holds the payload structs, command and operation codes, the register map
// and its reset values, and the duration helpers.
// ============================================================================
package rlps_pkg;

    // Payload widths fixed by the word format
    localparam int COLOR_W    = 8;
    localparam int CMD_W      = 2;
    localparam int RGB_W      = 3 * COLOR_W;
    localparam int SHORT_W    = 8;
    localparam int LONG_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = LONG_W;
    localparam int BIT_CNT_W  = 5;

    // Default pixel length
    localparam int BITS_PER_PIXEL_DEF = 24;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Input command codes
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PIXEL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LATCH = 2'd2;

    // Classified operation codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_PIXEL = 2'd1;
    localparam logic [1:0] OP_LATCH = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // Register map
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LATCH     = 3'd4;

    localparam logic [SHORT_W-1:0] ZERO_HIGH_RST = 8'd15;
    localparam logic [SHORT_W-1:0] ZERO_LOW_RST  = 8'd70;
    localparam logic [SHORT_W-1:0] ONE_HIGH_RST  = 8'd48;
    localparam logic [SHORT_W-1:0] ONE_LOW_RST   = 8'd38;
    localparam logic [LONG_W-1:0]  LATCH_RST     = 16'd500;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] blue;
    } in_word_t;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic accepted;
        logic latch_done;
    } out_word_t;

    typedef struct packed {
        logic [1:0]       op;
        logic [RGB_W-1:0] rgb;
    } item_t;

    typedef struct packed {
        logic [SHORT_W-1:0] zero_high;
        logic [SHORT_W-1:0] zero_low;
        logic [SHORT_W-1:0] one_high;
        logic [SHORT_W-1:0] one_low;
        logic [LONG_W-1:0]  latch;
    } cfg_t;

    // A zero duration counts as one tick
    function automatic logic [SHORT_W-1:0] at_least_one8(input logic [SHORT_W-1:0] v);
        at_least_one8 = (v == '0) ? SHORT_W'(1) : v;
    endfunction

    function automatic logic [LONG_W-1:0] at_least_one16(input logic [LONG_W-1:0] v);
        at_least_one16 = (v == '0) ? LONG_W'(1) : v;
    endfunction

endpackage

@@ src/rlps_front.sv @@
// ============================================================================
// rlps_front: input stage
// Accepts command words, classifies them into operations and holds one
// classified item until the queue takes it.
// ============================================================================
module rlps_front
    import rlps_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_word_t in_data,
    output logic     push_valid,
    input  logic     push_ready,
    output item_t    push_item
);

    logic  hold_valid_reg;
    logic  hold_valid_next;
    item_t hold_item_reg;
    item_t item_next;
    logic  in_accept;

    assign in_ready  = !hold_valid_reg || push_ready;
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        item_next.rgb = {in_data.green, in_data.red, in_data.blue};
        case (in_data.cmd)
            CMD_TICK:  item_next.op = OP_TICK;
            CMD_PIXEL: item_next.op = OP_PIXEL;
            CMD_LATCH: item_next.op = OP_LATCH;
            default:   item_next.op = OP_NONE;
        endcase
        // drop colour bits that no operation will use
        if (item_next.op != OP_PIXEL)
        begin
            item_next.rgb = '0;
        end
    end

    assign hold_valid_next = in_accept || (hold_valid_reg && !push_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            hold_item_reg <= item_next;
        end
    end

    assign push_valid = hold_valid_reg;
    assign push_item  = hold_item_reg;

endmodule

@@ src/rlps_queue.sv @@
// ============================================================================
// rlps_queue: item queue
// Small first-in first-out queue that decouples the input stage from the
// line timing engine.
// ============================================================================
module rlps_queue
    import rlps_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Fill level never passes the depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
    else $error("rlps_queue: fill level above depth");

endmodule

@@ src/rlps_engine.sv @@
// ============================================================================
// rlps_engine: line timing engine
// Unless the output stalls, executes one queued operation per cycle against
// the line state and registers the resulting status word for the output channel.
// ============================================================================
module rlps_engine
    import rlps_pkg::*;
#(
    parameter int BITS_PER_PIXEL = BITS_PER_PIXEL_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      pop_valid,
    output logic      pop_ready,
    input  item_t     pop_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data
);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_HIGH  = 2'd1;
    localparam logic [1:0] PH_LOW   = 2'd2;
    localparam logic [1:0] PH_LATCH = 2'd3;
    localparam int         PAD_W    = BITS_PER_PIXEL - RGB_W;

    logic [1:0]                phase_reg;
    logic [1:0]                phase_next;
    logic [LONG_W-1:0]         count_reg;
    logic [LONG_W-1:0]         count_next;
    logic [LONG_W-1:0]         count_dec;
    logic [BITS_PER_PIXEL-1:0] shift_reg;
    logic [BITS_PER_PIXEL-1:0] shift_next;
    logic [BITS_PER_PIXEL-1:0] rgb_ext;
    logic [BIT_CNT_W-1:0]      bits_reg;
    logic [BIT_CNT_W-1:0]      bits_next;
    logic                      acc;
    logic                      done;
    logic                      do_step;
    logic                      out_valid_reg;
    out_word_t                 out_data_reg;
    out_word_t                 out_data_next;

    assign pop_ready = !out_valid_reg || out_ready;
    assign do_step   = pop_valid && pop_ready;
    assign count_dec = count_reg - 1'b1;
    assign rgb_ext   = BITS_PER_PIXEL'(pop_item.rgb) << PAD_W;

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        shift_next = shift_reg;
        bits_next  = bits_reg;
        acc        = 1'b0;
        done       = 1'b0;
        case (pop_item.op)
            OP_TICK:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    count_next = count_dec;
                    if (count_dec == '0)
                    begin
                        case (phase_reg)
                            PH_HIGH:
                            begin
                                phase_next = PH_LOW;
                                count_next = LONG_W'(at_least_one8(
                                    shift_reg[BITS_PER_PIXEL-1] ? cfg.one_low : cfg.zero_low));
                            end
                            PH_LOW:
                            begin
                                if (bits_reg != '0)
                                begin
                                    // advance to the next bit, now at the top
                                    bits_next  = bits_reg - 1'b1;
                                    shift_next = shift_reg << 1;
                                    phase_next = PH_HIGH;
                                    count_next = LONG_W'(at_least_one8(
                                        shift_reg[BITS_PER_PIXEL-2] ? cfg.one_high
                                                                    : cfg.zero_high));
                                end
                                else
                                begin
                                    phase_next = PH_IDLE;
                                    shift_next = '0;
                                end
                            end
                            default:
                            begin
                                phase_next = PH_IDLE;
                                done       = 1'b1;
                            end
                        endcase
                    end
                end
            end
            OP_PIXEL:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    shift_next = rgb_ext;
                    bits_next  = BIT_CNT_W'(BITS_PER_PIXEL - 1);
                    phase_next = PH_HIGH;
                    count_next = LONG_W'(at_least_one8(
                        pop_item.rgb[RGB_W-1] ? cfg.one_high : cfg.zero_high));
                    acc        = 1'b1;
                end
            end
            OP_LATCH:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    phase_next = PH_LATCH;
                    count_next = at_least_one16(cfg.latch);
                    acc        = 1'b1;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
        out_data_next.line_level = (phase_next == PH_HIGH);
        out_data_next.busy_res   = (phase_next != PH_IDLE);
        out_data_next.accepted   = acc;
        out_data_next.latch_done = done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            shift_reg     <= '0;
            bits_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (do_step)
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                shift_reg <= shift_next;
                bits_reg  <= bits_next;
            end
            if (pop_ready)
            begin
                out_valid_reg <= pop_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_step)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // An active phase always has ticks left to run
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> (count_reg != '0))
    else $error("rlps_engine: active phase with empty counter");

    // A high line is only reported while busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.line_level) |-> out_data_reg.busy_res)
    else $error("rlps_engine: line high while not busy");

    // The end of a latch leaves the block idle and takes no command
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.latch_done)
            |-> (!out_data_reg.busy_res && !out_data_reg.accepted))
    else $error("rlps_engine: latch end with busy or accepted set");

endmodule

@@ src/rgb_led_pulse_width_serializer.sv @@
// ============================================================================
// rgb_led_pulse_width_serializer: one-wire RGB LED pulse width encoder
// Turns tick, pixel and latch words into a serial line level and status,
// one status word per input word.
// ============================================================================
//
// Channel   Dir  Handshake              Payload
// in        in   in_valid / in_ready    in_data   (cmd, green, red, blue)
// out       out  out_valid / out_ready  out_data  (line_level, busy_res,
//                                                   accepted, latch_done)
// cfg       in   cfg_wr_en              cfg_index, cfg_data
//
// Unless the output stalls, one word is taken and one status word leaves per
// cycle; the line timing engine retires one queued operation each cycle.
// A word passes the input stage, the queue and the engine's output register
// on its way to the output.
// Reset clears the line state to idle and the timing registers to their
// defaults; there is no clearing pass.
// A stalled output holds the engine; the queue absorbs the input stage's
// word so the input keeps flowing until the queue fills.
// ============================================================================
module rgb_led_pulse_width_serializer
    import rlps_pkg::*;
#(
    parameter int BITS_PER_PIXEL = BITS_PER_PIXEL_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_word_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_word_t             out_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    logic  push_valid;
    logic  push_ready;
    item_t push_item;
    logic  pop_valid;
    logic  pop_ready;
    item_t pop_item;

    // Timing registers: update the addressed one, ignore unmapped indexes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_ZERO_HIGH: cfg_next.zero_high = cfg_data[SHORT_W-1:0];
                CFG_ZERO_LOW:  cfg_next.zero_low  = cfg_data[SHORT_W-1:0];
                CFG_ONE_HIGH:  cfg_next.one_high  = cfg_data[SHORT_W-1:0];
                CFG_ONE_LOW:   cfg_next.one_low   = cfg_data[SHORT_W-1:0];
                CFG_LATCH:     cfg_next.latch     = cfg_data[LONG_W-1:0];
                default:       cfg_next           = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.zero_high <= ZERO_HIGH_RST;
            cfg_reg.zero_low  <= ZERO_LOW_RST;
            cfg_reg.one_high  <= ONE_HIGH_RST;
            cfg_reg.one_low   <= ONE_LOW_RST;
            cfg_reg.latch     <= LATCH_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: accept and classify
    rlps_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // Queue: decouple front and back stalls
    rlps_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // Back: run the line timing and register the status word
    rlps_engine #(
        .BITS_PER_PIXEL (BITS_PER_PIXEL)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

@@ bench/rgb_led_pulse_width_serializer_tb.sv @@
// ============================================================================
// rgb_led_pulse_width_serializer_tb: self-checking bench for the LED encoder
// Drives tick, pixel and latch words through the valid/ready input, predicts
// the status word for each accepted word with a word-by-word line model, and
// compares every status word leaving the block field by field. A short table
// of directed words comes first, then several timing settings, each with a
// run of random words shaped around whether the line is idle or busy.
// ============================================================================
module rgb_led_pulse_width_serializer_tb
    import rlps_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIX_BITS        = BITS_PER_PIXEL_DEF;
    localparam int SETTLE_CYCLES   = 8;
    localparam int TAIL_CYCLES     = 16;
    localparam int RAND_PHASES     = 4;
    localparam int WORDS_PER_PHASE = 125;
    localparam int CYCLE_LIMIT     = 4000000;
    localparam int PLAN_N          = 35;

    // The block ignores this code; it has no name in the package
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef enum logic [1:0] {LN_IDLE, LN_HIGH, LN_LOW, LN_LATCH} line_phase_t;
    typedef enum logic [1:0] {ROW_WORD, ROW_CFG, ROW_DRAIN} row_kind_t;

    // One row of the directed table: a word (with an optional typed-in
    // status), a register write, or a drain of the line back to idle
    typedef struct packed {
        row_kind_t              kind;
        logic [CMD_W-1:0]       cmd;
        logic [COLOR_W-1:0]     green;
        logic [COLOR_W-1:0]     red;
        logic [COLOR_W-1:0]     blue;
        logic                   typed;
        out_word_t              want;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  val;
    } plan_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_word_t              in_data;
    logic                  out_valid;
    logic                  out_ready;
    out_word_t             out_data;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Line model state and its copy of the timing registers
    cfg_t                  timing;
    logic [PIX_BITS-1:0]   pix_shift;
    logic [BIT_CNT_W-1:0]  bits_left;
    line_phase_t           line_ph;
    logic [LONG_W-1:0]     ph_count;

    // Status words owed by the block, oldest first
    out_word_t             status_q[$];
    int unsigned           fail_count = 0;
    int unsigned           cycle_count = 0;
    int                    burst_left = 0;

    // Receiver stall pattern
    logic [15:0]           ready_pat = 16'hFFFF;
    int                    ready_run = 0;

    plan_row_t             plan [0:PLAN_N-1];

    rgb_led_pulse_width_serializer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Line model
    // ------------------------------------------------------------------------

    // A programmed duration of zero lasts one tick
    function automatic logic [LONG_W-1:0] nonzero(input logic [LONG_W-1:0] v);
        nonzero = (v == '0) ? LONG_W'(1) : v;
    endfunction

    // Load the high pulse of the bit at the top of the shift register
    task automatic begin_pulse();
        line_ph  = LN_HIGH;
        ph_count = nonzero(pix_shift[PIX_BITS-1] ? LONG_W'(timing.one_high)
                                                 : LONG_W'(timing.zero_high));
    endtask

    // Spend one tick of the current phase; report the end of a latch period
    task automatic tick_line(output logic latch_end);
        latch_end = 1'b0;
        if (line_ph != LN_IDLE)
        begin
            ph_count = ph_count - 1'b1;
            if (ph_count == '0)
            begin
                case (line_ph)
                    LN_HIGH:
                    begin
                        line_ph  = LN_LOW;
                        ph_count = nonzero(pix_shift[PIX_BITS-1] ? LONG_W'(timing.one_low)
                                                                 : LONG_W'(timing.zero_low));
                    end
                    LN_LOW:
                    begin
                        if (bits_left != '0)
                        begin
                            bits_left = bits_left - 1'b1;
                            pix_shift = pix_shift << 1;
                            begin_pulse();
                        end
                        else
                        begin
                            // last gap done: back to idle
                            line_ph   = LN_IDLE;
                            pix_shift = '0;
                        end
                    end
                    default:
                    begin
                        line_ph   = LN_IDLE;
                        latch_end = 1'b1;
                    end
                endcase
            end
        end
    endtask

    // Work out the status word that one accepted word produces
    task automatic step_line(input in_word_t w, output out_word_t res);
        logic taken;
        logic latch_end;
        taken     = 1'b0;
        latch_end = 1'b0;
        case (w.cmd)
            CMD_TICK:
                tick_line(latch_end);
            CMD_PIXEL:
                if (line_ph == LN_IDLE)
                begin
                    pix_shift = PIX_BITS'({w.green, w.red, w.blue}) << (PIX_BITS - RGB_W);
                    bits_left = BIT_CNT_W'(PIX_BITS - 1);
                    begin_pulse();
                    taken = 1'b1;
                end
            CMD_LATCH:
                if (line_ph == LN_IDLE)
                begin
                    line_ph  = LN_LATCH;
                    ph_count = nonzero(timing.latch);
                    taken    = 1'b1;
                end
            default: ;
        endcase
        res.line_level = (line_ph == LN_HIGH);
        res.busy_res   = (line_ph != LN_IDLE);
        res.accepted   = taken;
        res.latch_done = latch_end;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Decide whether the sender keeps going or takes a gap after this word
    task automatic pace();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            // mostly short bursts, sometimes a long stretch with no gaps
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 16);
            gap = $urandom_range(0, 5);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Offer one word, hold it until taken, then queue its status word.
    // Valid stays high on return unless pace took a gap; the caller either offers
    // the next word or drops valid in this same step.
    task automatic push_word(input in_word_t w, input logic typed, input out_word_t want);
        out_word_t predicted;
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        step_line(w, predicted);
        status_q.push_back(typed ? want : predicted);
        pace();
    endtask

    task automatic hold_off();
        in_valid <= 1'b0;
    endtask

    // Wait for every owed status word, then let the pipeline settle
    task automatic wait_drained();
        while (status_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Tick word with junk colour bits, which the block ignores
    function automatic in_word_t tick_word();
        in_word_t w;
        w       = in_word_t'($urandom);
        w.cmd   = CMD_TICK;
        tick_word = w;
    endfunction

    // Advance the line until the model says it is idle again
    task automatic drain_line();
        while (line_ph != LN_IDLE) push_word(tick_word(), 1'b0, '0);
    endtask

    // Write one timing register with the block quiet
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        hold_off();
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_ZERO_HIGH: timing.zero_high = val[SHORT_W-1:0];
            CFG_ZERO_LOW:  timing.zero_low  = val[SHORT_W-1:0];
            CFG_ONE_HIGH:  timing.one_high  = val[SHORT_W-1:0];
            CFG_ONE_LOW:   timing.one_low   = val[SHORT_W-1:0];
            CFG_LATCH:     timing.latch     = val;
            default: ;
        endcase
    endtask

    // Bit time, mostly short so pixels finish; junk in the unused upper byte
    function automatic logic [CFG_DATA_W-1:0] pick_bit_time();
        logic [SHORT_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = '1;
            2:       v = SHORT_W'($urandom_range(5, 40));
            default: v = SHORT_W'($urandom_range(1, 4));
        endcase
        pick_bit_time = {SHORT_W'($urandom), v};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_latch_time();
        case ($urandom_range(0, 9))
            0:       pick_latch_time = '0;
            1:       pick_latch_time = CFG_DATA_W'($urandom_range(100, 2000));
            default: pick_latch_time = CFG_DATA_W'($urandom_range(1, 30));
        endcase
    endfunction

    // Favor commands while idle so pixels and latches run to the end;
    // commands while busy are the noise that must be dropped
    function automatic in_word_t fresh_word();
        in_word_t w;
        int       r;
        w = in_word_t'($urandom);
        r = $urandom_range(0, 99);
        if (line_ph == LN_IDLE)
            w.cmd = (r < 45) ? CMD_PIXEL : (r < 60) ? CMD_LATCH :
                    (r < 63) ? CMD_UNUSED : CMD_TICK;
        else
            w.cmd = (r < 6) ? CMD_PIXEL : (r < 10) ? CMD_LATCH :
                    (r < 12) ? CMD_UNUSED : CMD_TICK;
        fresh_word = w;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: stall on a rotating pattern that is replaced when its run counter has used up its cycles
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (ready_run == 0)
        begin
            ready_run <= $urandom_range(8, 80);
            case ($urandom_range(0, 3))
                0:       ready_pat <= 16'hFFFF;
                1:       ready_pat <= 16'($urandom);
                2:       ready_pat <= 16'h5555;
                default: ready_pat <= 16'h00FF;
            endcase
        end
        else
        begin
            ready_run <= ready_run - 1;
            ready_pat <= {ready_pat[0], ready_pat[15:1]};
        end
        out_ready <= ready_pat[0];
    end

    // ------------------------------------------------------------------------
    // Status word checker
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input logic want, input logic got);
        if (got !== want)
        begin
            fail_count++;
            $error("%s: expected %0b, got %0b", name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (status_q.size() == 0)
            begin
                fail_count++;
                $error("status word with none owed: %b", out_data);
            end
            else
            begin
                want = status_q.pop_front();
                check_field("line_level", want.line_level, out_data.line_level);
                check_field("busy_res",   want.busy_res,   out_data.busy_res);
                check_field("accepted",   want.accepted,   out_data.accepted);
                check_field("latch_done", want.latch_done, out_data.latch_done);
            end
        end
    end

    // Guard against a hung handshake
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d status words owed",
                     cycle_count, status_q.size());
            $display("rgb_led_pulse_width_serializer_tb: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        in_word_t w;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;

        timing.zero_high = ZERO_HIGH_RST;
        timing.zero_low  = ZERO_LOW_RST;
        timing.one_high  = ONE_HIGH_RST;
        timing.one_low   = ONE_LOW_RST;
        timing.latch     = LATCH_RST;
        pix_shift        = '0;
        bits_left        = '0;
        line_ph          = LN_IDLE;
        ph_count         = '0;

        // Directed rows. Status bits read line_level, busy_res, accepted,
        // latch_done; rows with typed 0 are left to the line model.
        plan = '{
            // reset timings: idle tick and unused code show a quiet line
            '{ROW_WORD,  CMD_TICK,   8'h00, 8'h00, 8'h00, 1'b1, 4'b0000, CFG_ZERO_HIGH, 16'd0},
            '{ROW_WORD,  CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF, 1'b1, 4'b0000, CFG_ZERO_HIGH, 16'd0},
            // latch, then a pixel that must be dropped during it
            '{ROW_WORD,  CMD_LATCH,  8'h00, 8'h00, 8'h00, 1'b1, 4'b0110, CFG_ZERO_HIGH, 16'd0},
            '{ROW_WORD,  CMD_PIXEL,  8'hFF, 8'hFF, 8'hFF, 1'b1, 4'b0100, CFG_ZERO_HIGH, 16'd0},
            '{ROW_DRAIN, CMD_TICK,   8'h00, 8'h00, 8'h00, 1'b0, 4'b0000, CFG_ZERO_HIGH, 16'd0},
            // pixel starts high without spending a tick; commands while busy drop
            '{ROW_WORD,  CMD_PIXEL,  8'hFF, 8'h00, 8'h00, 1'b1, 4'b1110, CFG_ZERO_HIGH, 16'd0},
            '{ROW_WORD,  CMD_LATCH,  8'h00, 8'h00, 8'h00, 1'b1, 4'b1100, CFG_ZERO_HIGH, 16'd0},
            '{ROW_WORD,  CMD_PIXEL,  8'h00, 8'h00, 8'h00, 1'b1, 4'b1100, CFG_ZERO_HIGH, 16'd0},
            '{ROW_WORD,  CMD_UNUSED, 8'h00, 8'h00, 8'h00, 1'b1, 4'b1100, CFG_ZERO_HIGH, 16'd0},
            '{ROW_WORD,  CMD_TICK,   8'h00, 8'h00, 8'h00, 1'b0, 4'b0000, CFG_ZERO_HIGH, 16'd0},
            '{ROW_DRAIN, CMD_TICK,   8'h00, 8'h00, 8'h00, 1'b0, 4'b0000, CFG_ZERO_HIGH, 16'd0},
            // shortest timings but for a long one-low time, zero durations among them
            '{ROW_CFG,   CMD_TICK,   8'h00, 8'h00, 8'h00, 1'b0, 4'b0000, CFG_ZERO_HIGH, 16'h0000},
            '{ROW_CFG,   CMD_TICK,   8'h00, 8'h00, 8'h00, 1'b0, 4'b0000, CFG_ZERO_LOW,  16'hFF01},
            '{ROW_CFG,   CMD_TICK,   8'h00, 8'h00, 8'h00, 1'b0, 4'b0000, CFG_ONE_HIGH,  16'h0001},
            '{ROW_CFG,   CMD_TICK,   8'h00, 8'h00, 8'h00, 1'b0, 4'b0000, CFG_ONE_LOW,   16'h00FF},
            '{ROW_CFG,   CMD_TICK,   8'h00, 8'h00, 8'h00, 1'b0, 4'b0000, CFG_LATCH,     16'h0000},
            // all-zero pixel: one-tick high, one-tick low, next bit high
            '{ROW_WORD,  CMD_PIXEL,  8'h00, 8'h00, 8'h00, 1'b1, 4'b1110, CFG_ZERO_HIGH, 16'd0},
            '{ROW_WORD,  CMD_TICK,   8'h00, 8'h00, 8'h00, 1'b1, 4'b0100, CFG_ZERO_HIGH, 16'd0},
            '{ROW_WORD,  CMD_TICK,   8'h00, 8'h00, 8'h00, 1'b1, 4'b1100, CFG_ZERO_HIGH, 16'd0},
            '{ROW_DRAIN, CMD_TICK,   8'h00, 8'h00, 8'h00, 1'b0, 4'b0000, CFG_ZERO_HIGH, 16'd0},
            // zero latch time ends on the first tick
            '{ROW_WORD,  CMD_LATCH,  8'h00, 8'h00, 8'h00, 1'b1, 4'b0110, CFG_ZERO_HIGH, 16'd0},
            '{ROW_WORD,  CMD_TICK,   8'h00, 8'h00, 8'h00, 1'b1, 4'b0001, CFG_ZERO_HIGH, 16'd0},
            '{ROW_WORD,  CMD_TICK,   8'h00, 8'h00, 8'h00, 1'b1, 4'b0000, CFG_ZERO_HIGH, 16'd0},
            '{ROW_WORD,  CMD_PIXEL,  8'hFF, 8'hFF, 8'hFF, 1'b1, 4'b1110, CFG_ZERO_HIGH, 16'd0},
            '{ROW_WORD,  CMD_TICK,   8'h00, 8'h00, 8'h00, 1'b0, 4'b0000, CFG_ZERO_HIGH, 16'd0},
            '{ROW_DRAIN, CMD_TICK,   8'h00, 8'h00, 8'h00, 1'b0, 4'b0000, CFG_ZERO_HIGH, 16'd0},
            // longest timings
            '{ROW_CFG,   CMD_TICK,   8'h00, 8'h00, 8'h00, 1'b0, 4'b0000, CFG_ONE_HIGH,  16'hA5FF},
            '{ROW_CFG,   CMD_TICK,   8'h00, 8'h00, 8'h00, 1'b0, 4'b0000, CFG_ZERO_HIGH, 16'h00FF},
            '{ROW_CFG,   CMD_TICK,   8'h00, 8'h00, 8'h00, 1'b0, 4'b0000, CFG_ZERO_LOW,  16'h00FF},
            '{ROW_CFG,   CMD_TICK,   8'h00, 8'h00, 8'h00, 1'b0, 4'b0000, CFG_LATCH,     16'hFFFF},
            '{ROW_WORD,  CMD_PIXEL,  8'h00, 8'hFF, 8'h00, 1'b1, 4'b1110, CFG_ZERO_HIGH, 16'd0},
            '{ROW_DRAIN, CMD_TICK,   8'h00, 8'h00, 8'h00, 1'b0, 4'b0000, CFG_ZERO_HIGH, 16'd0},
            '{ROW_WORD,  CMD_LATCH,  8'h00, 8'h00, 8'h00, 1'b1, 4'b0110, CFG_ZERO_HIGH, 16'd0},
            '{ROW_DRAIN, CMD_TICK,   8'h00, 8'h00, 8'h00, 1'b0, 4'b0000, CFG_ZERO_HIGH, 16'd0},
            '{ROW_WORD,  CMD_PIXEL,  8'h5A, 8'hA5, 8'h3C, 1'b0, 4'b0000, CFG_ZERO_HIGH, 16'd0}
        };

        // Hold reset, then release it on an edge
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            case (plan[i].kind)
                ROW_WORD:
                begin
                    w = {plan[i].cmd, plan[i].green, plan[i].red, plan[i].blue};
                    push_word(w, plan[i].typed, plan[i].want);
                end
                ROW_CFG:
                    write_reg(plan[i].idx, plan[i].val);
                default:
                    drain_line();
            endcase
        end

        // Random phases: the first at the minimum timings, the rest mixed
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            drain_line();
            for (int r = 0; r <= CFG_LATCH; r++)
            begin
                if (p == 0)
                    write_reg(CFG_IDX_W'(r), CFG_DATA_W'(1));
                else if (r == CFG_LATCH)
                    write_reg(CFG_IDX_W'(r), pick_latch_time());
                else
                    write_reg(CFG_IDX_W'(r), pick_bit_time());
            end
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                // hold the sender once mid-phase until the output catches up
                if (p == 1 && n == WORDS_PER_PHASE / 2)
                begin
                    hold_off();
                    wait_drained();
                end
                push_word(fresh_word(), 1'b0, '0);
            end
        end

        hold_off();
        while (status_q.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (status_q.size() != 0)
        begin
            fail_count++;
            $error("%0d status words never arrived", status_q.size());
        end

        if (fail_count == 0)
            $display("rgb_led_pulse_width_serializer_tb: PASS");
        else
            $display("rgb_led_pulse_width_serializer_tb: FAIL");
        $finish;
    end

endmodule
